FILE: rtl/pwl_pkg.sv
// Shared constants, status codes and controller/datapath command types
// for the piecewise linear interpolator. No dependencies.
package pwl_pkg;

    // Table geometry
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CFG_W      = 9;
    localparam int INDEX_W    = 8;
    localparam int DATA_W     = 32;

    // Stream word layouts
    localparam int IN_TDATA_W  = INDEX_W + 3 * DATA_W;
    localparam int STATUS_W    = 2;
    localparam int OUT_FIELD_W = DATA_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Iteration counts of the shift-add multiplier and restoring divider
    localparam int MUL_STEPS = DATA_W;
    localparam int DIV_STEPS = DATA_W + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Input word kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [STATUS_W-1:0] t_status;

    // Result status codes
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_RANGE      = 2'd1;
    localparam t_status ST_ZERO_WIDTH = 2'd2;
    localparam t_status ST_SAT        = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic              wr_en;
        logic              v_load;
        logic              scan;
        logic [ADDR_W-1:0] rd_addr;
        logic              seg_load;
        logic              mul_init;
        logic              mul_step;
        logic              div_init;
        logic              div_step;
        logic              base_load;
        logic              out_load;
        t_status           res_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic zero_width;
    } t_dp_stat;

endpackage

FILE: rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a 256-point breakpoint table in signed
// Q16.16. A write word (tuser 0) stores one point and gives no result. A
// query word (tuser 1) scans the segments one per cycle through the
// registered table read port, then runs a 32-step shift-add multiply and a
// 33-step restoring divide. The next word is taken while a finished result
// waits on the output. Status: 0 ok, 1 outside the table (or fewer than two
// points), 2 zero-width segment, 3 saturated. Table entries are undefined
// until written. Uses pwl_pkg, pwl_ctrl, pwl_dpath.
module piecewise_linear_interpolator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pwl_pkg::CFG_W-1:0]      i_cfg_wr_data, // num_points
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // point_index[7:0], point_x[39:8], point_y[71:40], query_value[103:72]
    input  logic [pwl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,  // command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // interp_value[31:0], status[33:32], zero fill above
    output logic [pwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pwl_pkg::*;

    t_dp_cmd                  dp_cmd;
    t_dp_stat                 dp_stat;
    logic signed [DATA_W-1:0] interp_value;
    t_status                  status;

    pwl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_command  (s_axis_tuser),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_cmd         (dp_cmd),
        .i_stat        (dp_stat)
    );

    pwl_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_point_index  (s_axis_tdata[INDEX_W-1:0]),
        .i_point_x      (signed'(s_axis_tdata[INDEX_W +: DATA_W])),
        .i_point_y      (signed'(s_axis_tdata[INDEX_W+DATA_W +: DATA_W])),
        .i_query_value  (signed'(s_axis_tdata[INDEX_W+2*DATA_W +: DATA_W])),
        .o_stat         (dp_stat),
        .o_interp_value (interp_value),
        .o_status       (status)
    );

    // Pack the result word
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, status, interp_value};

endmodule

FILE: rtl/pwl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pwl_dpath.sv
// Datapath: breakpoint tables, segment compare, shift-add multiplier,
// restoring divider, rounding and output register. Uses pwl_pkg, pwl_ram.
module pwl_dpath (
    input  logic                              i_clk,
    input  pwl_pkg::t_dp_cmd                  i_cmd,
    input  logic [pwl_pkg::INDEX_W-1:0]       i_point_index,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_query_value,
    output pwl_pkg::t_dp_stat                 o_stat,
    output logic signed [pwl_pkg::DATA_W-1:0] o_interp_value,
    output pwl_pkg::t_status                  o_status
);
    import pwl_pkg::*;

    localparam logic signed [DATA_W+1:0] RES_MAX = 34'sd2147483647;
    localparam logic signed [DATA_W+1:0] RES_MIN = -34'sd2147483648;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [DATA_W-1:0]        x_rdata;
    logic [DATA_W-1:0]        y_rdata;
    logic signed [DATA_W-1:0] cur_x;
    logic signed [DATA_W-1:0] cur_y;

    logic signed [DATA_W-1:0] r_v;
    logic signed [DATA_W-1:0] r_prev_x;
    logic signed [DATA_W-1:0] r_prev_y;
    logic [DATA_W-1:0]        r_d;
    logic [DATA_W-1:0]        r_b;
    logic signed [DATA_W:0]   r_dy;
    logic signed [DATA_W-1:0] r_y1;
    logic [DATA_W:0]          r_a;
    logic                     r_neg;
    logic [DATA_W:0]          r_hi;
    logic [DATA_W-1:0]        r_lo;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W:0]          r_quo;
    logic signed [DATA_W+1:0] r_base;
    logic                     r_rem_nz;
    logic signed [DATA_W-1:0] r_out_value;
    t_status                  r_out_status;

    logic [DATA_W+1:0]        mul_sum;
    logic [DATA_W:0]          div_trial;
    logic [DATA_W+1:0]        div_diff;
    logic                     div_ge;
    logic signed [DATA_W+1:0] y1_ext;
    logic signed [DATA_W+1:0] q_ext;
    logic signed [DATA_W+1:0] fin;
    logic signed [DATA_W-1:0] calc_value;
    t_status                  calc_status;

    // Tables share one port: writes while idle, reads during the scan
    assign ram_we   = i_cmd.wr_en && (32'(i_point_index) < MAX_POINTS);
    assign ram_addr = i_cmd.wr_en ? ADDR_W'(i_point_index) : i_cmd.rd_addr;

    pwl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_point_x),
        .o_rdata (x_rdata)
    );

    pwl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_point_y),
        .o_rdata (y_rdata)
    );

    assign cur_x = signed'(x_rdata);
    assign cur_y = signed'(y_rdata);

    // Segment test: previous point against the one just read
    assign o_stat.hit        = (r_v >= r_prev_x) && (r_v <= cur_x);
    assign o_stat.zero_width = (r_prev_x == cur_x);

    // One shift-add step: add a when the low multiplier bit is set
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // One restoring divide step
    assign div_trial = {r_rem, r_quo[DATA_W]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, r_d};
    assign div_ge    = !div_diff[DATA_W+1];

    assign y1_ext = {{2{r_y1[DATA_W-1]}}, r_y1};
    assign q_ext  = signed'({1'b0, r_quo});

    // Truncate toward zero, then saturate
    always_comb begin
        fin = r_base;
        if (r_rem_nz && !r_neg && (r_base < 0)) begin
            fin = r_base + 34'sd1;
        end else if (r_rem_nz && r_neg && (r_base > 0)) begin
            fin = r_base - 34'sd1;
        end
        priority if (fin > RES_MAX) begin
            calc_value  = RES_MAX[DATA_W-1:0];
            calc_status = ST_SAT;
        end else if (fin < RES_MIN) begin
            calc_value  = RES_MIN[DATA_W-1:0];
            calc_status = ST_SAT;
        end else begin
            calc_value  = fin[DATA_W-1:0];
            calc_status = ST_OK;
        end
    end

    // Datapath registers, each loaded on its command
    always_ff @(posedge i_clk) begin
        if (i_cmd.v_load) begin
            r_v <= i_query_value;
        end
        if (i_cmd.scan) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        if (i_cmd.seg_load) begin
            r_d  <= DATA_W'(cur_x - r_prev_x);
            r_b  <= DATA_W'(r_v - r_prev_x);
            r_dy <= {cur_y[DATA_W-1], cur_y} - {r_prev_y[DATA_W-1], r_prev_y};
            r_y1 <= r_prev_y;
        end
        if (i_cmd.mul_init) begin
            r_neg <= r_dy[DATA_W];
            r_a   <= r_dy[DATA_W] ? (DATA_W+1)'(-r_dy) : (DATA_W+1)'(r_dy);
            r_hi  <= '0;
            r_lo  <= r_b;
        end
        if (i_cmd.mul_step) begin
            r_hi <= mul_sum[DATA_W+1:1];
            r_lo <= {mul_sum[0], r_lo[DATA_W-1:1]};
        end
        if (i_cmd.div_init) begin
            r_rem <= r_hi[DATA_W:1];
            r_quo <= {r_hi[0], r_lo};
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-1:0], div_ge};
        end
        if (i_cmd.base_load) begin
            r_base   <= r_neg ? (y1_ext - q_ext) : (y1_ext + q_ext);
            r_rem_nz <= (r_rem != '0);
        end
        if (i_cmd.out_load) begin
            if (i_cmd.res_sel == ST_OK) begin
                r_out_value  <= calc_value;
                r_out_status <= calc_status;
            end else begin
                r_out_value  <= '0;
                r_out_status <= i_cmd.res_sel;
            end
        end
    end

    assign o_interp_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

FILE: rtl/pwl_ctrl.sv
// Controller: point count register, segment scan sequencing, multiply and
// divide step counts, output word valid. Uses pwl_pkg.
module pwl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [pwl_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_in_command,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pwl_pkg::t_dp_cmd          o_cmd,
    input  pwl_pkg::t_dp_stat         i_stat
);
    import pwl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIVI  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_BASE  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       r_state,      n_state;
    logic [CFG_W-1:0] r_num_points, n_num_points;
    logic [CNT_W-1:0] r_n,          n_n;
    logic [CNT_W-1:0] r_idx,        n_idx;
    logic [STEP_W-1:0] r_step,      n_step;
    t_status          r_res,        n_res;
    logic             r_out_valid,  n_out_valid;
    logic [CNT_W-1:0] n_eff;

    // Clamp the configured count to the table size
    assign n_eff = (32'(r_num_points) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                     : CNT_W'(r_num_points);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_num_points  = r_num_points;
        n_n           = r_n;
        n_idx         = r_idx;
        n_step        = r_step;
        n_res         = r_res;
        o_cmd         = '0;
        o_cmd.rd_addr = r_idx[ADDR_W-1:0];
        o_cmd.res_sel = r_res;

        if (i_cfg_wr_en) begin
            n_num_points = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == CMD_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.v_load = 1'b1;
                        n_n          = n_eff;
                        n_idx        = '0;
                        if (n_eff < CNT_W'(2)) begin
                            n_res   = ST_RANGE;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Read one point a cycle; test once two points are present
                o_cmd.scan = 1'b1;
                priority if (r_idx >= CNT_W'(2) && i_stat.hit) begin
                    if (i_stat.zero_width) begin
                        n_res   = ST_ZERO_WIDTH;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.seg_load = 1'b1;
                        n_res          = ST_OK;
                        n_state        = S_PREP;
                    end
                end else if (r_idx >= CNT_W'(2) && r_idx == r_n) begin
                    n_res   = ST_RANGE;
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_PREP: begin
                o_cmd.mul_init = 1'b1;
                n_step         = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_DIVI;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_BASE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_BASE: begin
                o_cmd.base_load = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output word valid
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_points <= '0;
            r_n          <= '0;
            r_idx        <= '0;
            r_step       <= '0;
            r_res        <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_num_points <= n_num_points;
            r_n          <= n_n;
            r_idx        <= n_idx;
            r_step       <= n_step;
            r_res        <= n_res;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

FILE: rtl/pwl_checker.sv
// Port-level checks for the piecewise linear interpolator, bound to the
// top level. Uses pwl_pkg.
module pwl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pwl_pkg::*;

    t_status out_status;
    assign out_status = m_axis_tdata[DATA_W +: STATUS_W];

    // Reset leaves no word on the output and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled after reset");

    // A point write never produces a word
    a_write_silent: assert property (@(posedge i_clk)
        i_rst_n && s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE)
        |=> !$rose(m_axis_tvalid))
        else $error("result word after a point write");

    // Range and zero-width results carry a zero value
    a_fail_zero: assert property (@(posedge i_clk)
        i_rst_n && m_axis_tvalid
        && (out_status == ST_RANGE || out_status == ST_ZERO_WIDTH)
        |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("nonzero value with failing status");

    // The result lies between two table ordinates, so it never saturates
    a_no_sat: assert property (@(posedge i_clk)
        i_rst_n && m_axis_tvalid |-> (out_status != ST_SAT))
        else $error("saturated result");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk)
        i_rst_n && m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind piecewise_linear_interpolator pwl_checker u_pwl_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for piecewise_linear_interpolator: drives point
// writes and queries as stream words and checks every result word against
// a table predictor or a typed row's result. Uses pwl_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
    import pwl_pkg::*;

    localparam int WORD_TARGET = 1300;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DIR_COUNT   = 24;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        t_status           status;
    } t_interp;

    // One row of the directed table; a typed row carries its own result
    typedef struct packed {
        bit                 cfg_wr;
        logic [CFG_W-1:0]   cfg_val;
        logic               cmd;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  px;
        logic [DATA_W-1:0]  py;
        logic [DATA_W-1:0]  qv;
        bit                 typed;
        logic [DATA_W-1:0]  t_val;
        t_status            t_st;
    } t_dir_row;

    typedef enum {SHAPE_RISING, SHAPE_FLAT, SHAPE_TIGHT, SHAPE_EXTREME, SHAPE_NOISE} t_shape;

    // Directed words: empty table, zero-width segment, misses, few points,
    // full-range endpoints, steepest falling slope and truncation toward zero
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // cfg  count    cmd        idx    point_x       point_y       query
        //                                                           typed value   status
        '{1'b1, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h0,
          1'b1, 32'h0,        ST_RANGE},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd0, 32'h7,        32'h64,       32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd1, 32'h7,        32'hFFFFFFFD, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b1, 9'd2,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h7,
          1'b1, 32'h0,        ST_ZERO_WIDTH},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h8,
          1'b1, 32'h0,        ST_RANGE},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h6,
          1'b1, 32'h0,        ST_RANGE},
        '{1'b1, 9'd1,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h7,
          1'b1, 32'h0,        ST_RANGE},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd0, 32'h80000000, 32'h80000000, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b1, 9'd2,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h80000000,
          1'b1, 32'h80000000, ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h7FFFFFFF,
          1'b1, 32'h7FFFFFFF, ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'hFFFFFFFF,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd0, 32'h80000000, 32'h7FFFFFFF, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd1, 32'h7FFFFFFF, 32'h80000000, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h3039,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd2, 32'h7FFFFFFF, 32'h0,        32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b1, 9'd3,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h7FFFFFFF,
          1'b1, 32'h80000000, ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd0, 32'h0,        32'hFFFFFFFF, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd1, 32'h3,        32'h1,        32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h1,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_WRITE, 8'd2, 32'h6,        32'hFFFFFFFC, 32'h0,
          1'b0, 32'h0,        ST_OK},
        '{1'b0, 9'd0,   CMD_QUERY, 8'd0, 32'h0,        32'h0,        32'h4,
          1'b0, 32'h0,        ST_OK}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_W-1:0]        i_cfg_wr_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // point_index, point_x, point_y, query_value
    logic                    s_axis_tuser;   // command
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // interp_value, status, zero fill

    // Shadow of the block state and the results still owed
    logic signed [DATA_W-1:0] x_tab [MAX_POINTS];
    logic signed [DATA_W-1:0] y_tab [MAX_POINTS];
    logic [CFG_W-1:0]         pt_count;
    t_interp                  expected_interp [$];

    int      words_sent  = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    int      hold_left   = 0;
    bit      idle_on     = 1'b1;
    t_interp owed;

    piecewise_linear_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Interpolate at v over the first enclosing segment of the shadow table
    function automatic t_interp interp_at(input logic signed [DATA_W-1:0] v);
        int unsigned       n;
        int unsigned       i;
        longint            vv, x1, x2, y1, y2, dy, base, res;
        longint unsigned   a, b, d, prod, q, r;
        bit                neg;
        t_interp           out;
        out.value  = '0;
        out.status = ST_RANGE;
        vv = v;
        n  = (pt_count > MAX_POINTS) ? MAX_POINTS : pt_count;
        for (i = 0; i + 1 < n; i++) begin
            x1 = x_tab[i];
            x2 = x_tab[i + 1];
            if (vv >= x1 && vv <= x2) begin
                if (x1 == x2) begin
                    out.status = ST_ZERO_WIDTH;
                    return out;
                end
                y1   = y_tab[i];
                y2   = y_tab[i + 1];
                dy   = y2 - y1;
                neg  = dy < 0;
                a    = neg ? -dy : dy;
                b    = vv - x1;
                d    = x2 - x1;
                prod = a * b;
                q    = prod / d;
                r    = prod % d;
                base = neg ? y1 - longint'(q) : y1 + longint'(q);
                res  = base;
                // Floor of the magnitude moved toward zero when inexact
                if (r != 0) begin
                    if (!neg && base < 0)
                        res = base + 1;
                    else if (neg && base > 0)
                        res = base - 1;
                end
                if (res > 64'sd2147483647) begin
                    out.value  = 32'h7FFFFFFF;
                    out.status = ST_SAT;
                end else if (res < -64'sd2147483648) begin
                    out.value  = 32'h80000000;
                    out.status = ST_SAT;
                end else begin
                    out.value  = res[DATA_W-1:0];
                    out.status = ST_OK;
                end
                return out;
            end
        end
        return out;
    endfunction

    // Pick a query: mostly inside or on the ends of a segment in use
    function automatic logic [DATA_W-1:0] pick_query();
        int              n, seg, roll;
        longint          lo, hi, tmp;
        longint unsigned off;
        n    = (pt_count > MAX_POINTS) ? MAX_POINTS : pt_count;
        roll = $urandom_range(0, 99);
        if (n < 2 || roll < 20)
            return $urandom;
        seg = $urandom_range(0, n - 2);
        if ($urandom_range(0, 1) == 1)
            seg = $urandom_range(0, (n - 2 < 7) ? n - 2 : 7);
        lo = x_tab[seg];
        hi = x_tab[seg + 1];
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        if (roll < 30)
            return (roll < 25) ? lo[DATA_W-1:0] : hi[DATA_W-1:0];
        off = {$urandom, $urandom} % (longint'(hi - lo) + 1);
        return DATA_W'(lo + longint'(off));
    endfunction

    // Offer one word, wait for the handshake, then update the shadow state
    task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                             input logic [DATA_W-1:0] qv, input bit typed,
                             input t_interp typed_res);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        word = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        if (cmd == CMD_WRITE)
            word[INDEX_W + 2*DATA_W - 1:0] = {py, px, idx};
        else
            word[IN_TDATA_W-1 -: DATA_W] = qv;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_WRITE) begin
            x_tab[idx] = px;
            y_tab[idx] = py;
        end else begin
            expected_interp.push_back(typed ? typed_res : interp_at(qv));
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed result is back and writes settle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_interp.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the point count while the block is idle
    task automatic load_count(input logic [CFG_W-1:0] n);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pt_count = n;
    endtask

    // Rewrite table slots 0..count-1 with points of the given shape
    task automatic build_points(input t_shape shape, input int count);
        longint            cur;
        int unsigned       stepmax;
        logic [DATA_W-1:0] px, py;
        int                i;
        stepmax = 32'((64'd4294967296 - 64'd2097152) / count);
        cur     = -64'sd2147483648 + $urandom_range(0, 1 << 20);
        for (i = 0; i < count; i++) begin
            px = cur[DATA_W-1:0];
            py = $urandom;
            case (shape)
                SHAPE_NOISE: begin
                    px = $urandom;
                end
                SHAPE_TIGHT: begin
                    py  = $urandom_range(0, 128) - 64;
                    cur = cur + $urandom_range(1, 16);
                end
                SHAPE_EXTREME: begin
                    py  = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
                    cur = cur + stepmax;
                end
                SHAPE_FLAT: begin
                    if ($urandom_range(0, 3) != 0)
                        cur = cur + $urandom_range(1, stepmax);
                end
                default: begin
                    cur = cur + $urandom_range(1, stepmax);
                end
            endcase
            send_word(CMD_WRITE, i[INDEX_W-1:0], px, py, '0, 1'b0, '0);
        end
    endtask

    // Run timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Check each accepted result word against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_interp.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                error_count++;
            end else begin
                owed = expected_interp.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== owed.value) begin
                    $error("interp_value mismatch: expected %h, got %h",
                           owed.value, m_axis_tdata[DATA_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[DATA_W +: STATUS_W] !== owed.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           owed.status, m_axis_tdata[DATA_W +: STATUS_W]);
                    error_count++;
                end
            end
        end
    end

    // Result side: random hold-off per word, plus a long hold on request
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                while (hold_left > 0) begin
                    @(negedge i_clk);
                    hold_left--;
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Stimulus: reset, directed table, table fill, then random phases
    initial begin : stimulus
        int     phase, n, k, burst, roll;
        t_shape shape;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        pt_count      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_COUNT; r++) begin
            if (DIR_ROWS[r].cfg_wr)
                load_count(DIR_ROWS[r].cfg_val);
            send_word(DIR_ROWS[r].cmd, DIR_ROWS[r].idx, DIR_ROWS[r].px, DIR_ROWS[r].py,
                      DIR_ROWS[r].qv, DIR_ROWS[r].typed,
                      t_interp'{DIR_ROWS[r].t_val, DIR_ROWS[r].t_st});
        end

        // Write every slot once so any count is safe to scan
        build_points(SHAPE_RISING, MAX_POINTS);

        phase = 0;
        while (words_sent < WORD_TARGET) begin
            roll = $urandom_range(0, 99);
            case (phase)
                0: n = 511;
                1: n = MAX_POINTS;
                2: n = 0;
                3: n = 1;
                4: n = 2;
                default: begin
                    if (roll < 4)       n = $urandom_range(0, 1);
                    else if (roll < 10) n = MAX_POINTS;
                    else if (roll < 13) n = $urandom_range(MAX_POINTS + 1, 511);
                    else if (roll < 25) n = $urandom_range(2, MAX_POINTS - 1);
                    else                n = $urandom_range(2, 12);
                end
            endcase
            load_count(n[CFG_W-1:0]);
            idle_on = ($urandom_range(0, 4) != 0);

            // Refresh the slots in use with a new shape now and then
            if (phase >= 4 && $urandom_range(0, 9) < 4) begin
                k    = (n > MAX_POINTS) ? MAX_POINTS : ((n < 2) ? 2 : n);
                roll = $urandom_range(0, 99);
                if (roll < 35)      shape = SHAPE_RISING;
                else if (roll < 50) shape = SHAPE_FLAT;
                else if (roll < 75) shape = SHAPE_TIGHT;
                else if (roll < 85) shape = SHAPE_EXTREME;
                else                shape = SHAPE_NOISE;
                build_points(shape, k);
            end

            // Back up the block: long result hold while queries keep coming
            if (phase == 6) begin
                hold_left = 1500;
                idle_on   = 1'b0;
            end

            burst = $urandom_range(15, 40);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 85)
                    send_word(CMD_QUERY, '0, '0, '0, pick_query(), 1'b0, '0);
                else
                    send_word(CMD_WRITE, INDEX_W'($urandom), $urandom, $urandom, '0,
                              1'b0, '0);
            end
            phase++;
        end

        settle();
        repeat (400) @(negedge i_clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/pwl_pkg.sv
rtl/pwl_ram.sv
rtl/pwl_dpath.sv
rtl/pwl_ctrl.sv
rtl/piecewise_linear_interpolator.sv
rtl/pwl_checker.sv
tb/testbench.sv
